[rtl/casl_pkg.sv]
// casl_pkg: widths, fixed-point pi constants and the angle wrap function
// for the circular angle slew limiter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package casl_pkg;

   localparam int ANGLE_FRAC_BITS = 16;
   localparam int ANGLE_INT_BITS  = 8;

   localparam int IN_W   = ANGLE_INT_BITS + ANGLE_FRAC_BITS;
   localparam int STEP_W = ANGLE_FRAC_BITS + 3;
   localparam int ANG_W  = ANGLE_FRAC_BITS + 3;
   localparam int CMP_W  = ANG_W + 2;

   // pi with 62 fraction bits, rounded to nearest at ANGLE_FRAC_BITS
   localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C234;
   localparam logic [63:0] PI_FIX_64 =
      (PI_Q62 + (64'd1 << (61 - ANGLE_FRAC_BITS))) >> (62 - ANGLE_FRAC_BITS);
   localparam logic [63:0] TWO_PI_FIX_64 =
      (PI_Q62 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);

   localparam logic [ANG_W-1:0] PI_FIX     = PI_FIX_64[ANG_W-1:0];
   localparam logic [ANG_W-1:0] TWO_PI_FIX = TWO_PI_FIX_64[ANG_W-1:0];

   localparam logic signed [CMP_W-1:0] PI_CMP     = CMP_W'(PI_FIX_64);
   localparam logic signed [CMP_W-1:0] TWO_PI_CMP = CMP_W'(TWO_PI_FIX_64);

   // coarse reduction: top input bits select a multiple of 2pi
   localparam int KEY_SHIFT = ANGLE_FRAC_BITS + 2;
   localparam int KEY_W     = IN_W - KEY_SHIFT;
   localparam int KEY_N     = 2 ** KEY_W;
   localparam int RED_W     = IN_W + 2;

   localparam longint TWO_PI_L = longint'(TWO_PI_FIX_64);
   localparam logic signed [RED_W-1:0] TWO_PI_RED = RED_W'(TWO_PI_FIX_64);

   typedef logic signed [IN_W:0] base_type;
   typedef base_type base_arr_type [KEY_N];

   function automatic base_arr_type build_base();
      base_arr_type tab;
      longint key;
      longint num;
      longint quo;
      for (int i = 0; i < KEY_N; i++) begin
         key = (i >= KEY_N / 2) ? longint'(i) - longint'(KEY_N) : longint'(i);
         num = key * (longint'(1) << KEY_SHIFT);
         if (num >= 0) begin
            quo = num / TWO_PI_L;
         end else begin
            quo = -((-num + TWO_PI_L - 1) / TWO_PI_L);
         end
         tab[i] = base_type'(quo * TWO_PI_L);
      end
      return tab;
   endfunction

   localparam base_arr_type BASE_TABLE = build_base();

   // reduce a signed angle into [0, 2pi)
   function automatic logic [ANG_W-1:0] wrap_input(input logic signed [IN_W-1:0] a);
      logic [KEY_W-1:0] key;
      base_type base;
      logic signed [RED_W-1:0] r0;
      logic signed [RED_W-1:0] r1;
      key  = a[IN_W-1:KEY_SHIFT];
      base = BASE_TABLE[key];
      r0   = RED_W'(a) - RED_W'(base);
      r1   = (r0 >= TWO_PI_RED) ? r0 - TWO_PI_RED : r0;
      return r1[ANG_W-1:0];
   endfunction

endpackage
`default_nettype wire

[rtl/circular_angle_slew_limiter_unit.sv]
// circular_angle_slew_limiter_unit: top level, moves an angle toward a target
// by at most one step the short way round. Depends on casl_pkg.
`timescale 1ns / 1ps
`default_nettype none
// A request is taken whenever start is high; busy is always low, so one
// request can enter every cycle. Each result passes the wrap register and
// then the output register and is shown for one cycle, marked by rsp_valid:
// the wrap stage reduces both angles modulo 2pi through a small table and one
// compare-subtract, the step stage compares distances, steps and wraps. The
// receiver cannot stall, so results must be captured in the cycle they are shown.
module circular_angle_slew_limiter_unit
   import casl_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic signed [IN_W-1:0] req_current_angle,
   input  wire logic signed [IN_W-1:0] req_target_angle,
   input  wire logic [STEP_W-1:0]      req_step_size,
   output logic                        rsp_valid,
   output logic [ANG_W-1:0]            rsp_next_angle
);

   logic                valid_ff;
   logic [ANG_W-1:0]    cur_ff;
   logic [ANG_W-1:0]    tgt_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                rsp_valid_ff;
   logic [ANG_W-1:0]    rsp_angle_ff;
   logic [ANG_W-1:0]    rsp_angle_in;

   logic signed [CMP_W-1:0] cur_x;
   logic signed [CMP_W-1:0] tgt_x;
   logic signed [CMP_W-1:0] step_x;
   logic signed [CMP_W-1:0] diff_s;
   logic signed [CMP_W-1:0] dist_abs;
   logic signed [CMP_W-1:0] around_a;
   logic signed [CMP_W-1:0] around_b;
   logic signed [CMP_W-1:0] sum;
   logic signed [CMP_W-1:0] sum_wrap;
   logic                    near;
   logic                    far;
   logic                    near_around;
   logic                    move_up;

   assign busy = 1'b0;

   // wrap stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start;
      end
      cur_ff  <= wrap_input(req_current_angle);
      tgt_ff  <= wrap_input(req_target_angle);
      step_ff <= req_step_size;
   end

   // step stage
   always_comb begin
      cur_x       = CMP_W'(cur_ff);
      tgt_x       = CMP_W'(tgt_ff);
      step_x      = CMP_W'(step_ff);
      diff_s      = tgt_x - cur_x;
      dist_abs    = (diff_s < 0) ? -diff_s : diff_s;
      near        = (dist_abs <= step_x);
      far         = (dist_abs > PI_CMP);
      around_a    = cur_x + TWO_PI_CMP - tgt_x;
      around_b    = tgt_x + TWO_PI_CMP - cur_x;
      near_around = (around_a < step_x) || (around_b < step_x);
      move_up     = (diff_s > 0) ^ far;
      sum         = move_up ? cur_x + step_x : cur_x - step_x;
      if (sum < 0) begin
         sum_wrap = sum + TWO_PI_CMP;
      end else if (sum >= TWO_PI_CMP) begin
         sum_wrap = sum - TWO_PI_CMP;
      end else begin
         sum_wrap = sum;
      end
      if (near || (far && near_around)) begin
         rsp_angle_in = tgt_ff;
      end else begin
         rsp_angle_in = sum_wrap[ANG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff;
      end
      rsp_angle_ff <= rsp_angle_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_angle = rsp_angle_ff;

endmodule
`default_nettype wire

[rtl/casl_checker.sv]
// casl_checker: port-level assertions for circular_angle_slew_limiter_unit,
// bound to the top level. Depends on casl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module casl_checker
   import casl_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire logic signed [IN_W-1:0] req_current_angle,
   input wire logic signed [IN_W-1:0] req_target_angle,
   input wire logic [STEP_W-1:0]      req_step_size,
   input wire logic                   rsp_valid,
   input wire logic [ANG_W-1:0]       rsp_next_angle
);

   // every accepted request is followed by a response
   a_rsp_follows : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("request without response");

   // no response without a request
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      !start |=> ##1 !rsp_valid)
      else $error("response without request");

   // result is always wrapped
   a_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_next_angle < TWO_PI_FIX))
      else $error("result outside [0, 2pi)");

   // equal input angles inside [0, 2pi) return the target
   a_equal_angles : assert property (@(posedge clock) disable iff (reset)
      (start && (req_current_angle == req_target_angle) && !req_target_angle[IN_W-1]
       && (req_target_angle < $signed(IN_W'(TWO_PI_FIX))))
      |=> ##1 (rsp_next_angle == $past(req_target_angle[ANG_W-1:0], 2)))
      else $error("equal angles did not return target");

endmodule

bind circular_angle_slew_limiter_unit casl_checker u_casl_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_current_angle (req_current_angle),
   .req_target_angle  (req_target_angle),
   .req_step_size     (req_step_size),
   .rsp_valid         (rsp_valid),
   .rsp_next_angle    (rsp_next_angle)
);
`default_nettype wire

[dv/circular_angle_slew_limiter_unit_tb.sv]
// circular_angle_slew_limiter_unit_tb: directed table and random requests checked
// against an in-bench slew predictor, with sender gaps in several phases.
// Depends on casl_pkg and circular_angle_slew_limiter_unit.
`timescale 1ns / 1ps
module circular_angle_slew_limiter_unit_tb;
   import casl_pkg::*;

   localparam longint HALF_TURN    = 205887;
   localparam longint FULL_TURN    = 411775;
   localparam int     RANDOM_ITEMS = 1950;
   localparam int     PHASE_LEN    = 325;
   localparam int     PLAN_LEN     = 20;

   typedef struct packed {
      logic signed [IN_W-1:0] cur;
      logic signed [IN_W-1:0] tgt;
      logic [STEP_W-1:0]      step;
      logic                   known;
      logic [ANG_W-1:0]       angle;
   } row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic signed [IN_W-1:0] req_current_angle = '0;
   logic signed [IN_W-1:0] req_target_angle  = '0;
   logic [STEP_W-1:0]      req_step_size     = '0;
   logic                   rsp_valid;
   logic [ANG_W-1:0]       rsp_next_angle;

   logic [ANG_W-1:0] next_angle_q [$];
   int               mismatch_count = 0;
   int               idle_pct       = 0;

   // cur, tgt, step, typed-in flag, typed-in angle
   row_type plan [PLAN_LEN] = '{
      '{0, 0, 0, 1'b1, 0},
      '{-8388608, 8388607, 524287, 1'b1, 153107},
      '{8388607, -8388608, 0, 1'b0, 0},
      '{0, -411775, 0, 1'b1, 0},
      '{-823550, -1235325, 0, 1'b1, 0},
      '{0, 1000, 1000, 1'b1, 1000},
      '{0, 1000, 999, 1'b0, 0},
      '{10, 411765, 5, 1'b0, 0},
      '{10, 411765, 25, 1'b1, 411765},
      '{10, 411765, 20, 1'b1, 411765},
      '{5, 300000, 100, 1'b0, 0},
      '{411770, 100, 50, 1'b0, 0},
      '{0, 205887, 1, 1'b0, 0},
      '{0, 205888, 1, 1'b0, 0},
      '{0, 300000, 411775, 1'b1, 300000},
      '{-1, -2, 0, 1'b0, 0},
      '{411775, 0, 7, 1'b1, 0},
      '{123456, 123456, 0, 1'b1, 123456},
      '{-205887, 205888, 3, 1'b0, 0},
      '{8388607, 8388607, 524287, 1'b1, 153107}
   };

   circular_angle_slew_limiter_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_current_angle (req_current_angle),
      .req_target_angle  (req_target_angle),
      .req_step_size     (req_step_size),
      .rsp_valid         (rsp_valid),
      .rsp_next_angle    (rsp_next_angle)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint wrap_turn(input longint a);
      longint r;
      r = a % FULL_TURN;
      if (r < 0) begin
         r = r + FULL_TURN;
      end
      return r;
   endfunction

   function automatic logic [ANG_W-1:0] slew_toward(input logic signed [IN_W-1:0] cur,
                                                    input logic signed [IN_W-1:0] tgt,
                                                    input logic [STEP_W-1:0] step);
      longint c;
      longint t;
      longint s;
      longint d;
      longint dir;
      longint span;
      longint res;
      c    = wrap_turn(longint'(cur));
      t    = wrap_turn(longint'(tgt));
      s    = longint'(step);
      d    = t - c;
      dir  = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
      span = (d < 0) ? -d : d;
      if (span <= s) begin
         res = t;
      end else if (span > HALF_TURN) begin
         if (c + FULL_TURN - t < s || t + FULL_TURN - c < s) begin
            res = t;
         end else begin
            res = wrap_turn(c - dir * s);
         end
      end else begin
         res = wrap_turn(c + dir * s);
      end
      return res[ANG_W-1:0];
   endfunction

   // fold back into the signed input range by whole turns
   function automatic logic signed [IN_W-1:0] fit_angle(input longint v);
      while (v > 8388607) v = v - FULL_TURN;
      while (v < -8388608) v = v + FULL_TURN;
      return v[IN_W-1:0];
   endfunction

   task automatic make_request(output logic signed [IN_W-1:0] cur,
                               output logic signed [IN_W-1:0] tgt,
                               output logic [STEP_W-1:0] step);
      int     kind;
      longint turns;
      longint offset;
      kind  = $urandom_range(9);
      turns = longint'($urandom_range(6)) - 3;
      cur   = IN_W'($urandom);
      tgt   = IN_W'($urandom);
      step  = STEP_W'($urandom_range(4095));
      case (kind)
         3, 4: begin
            offset = longint'($urandom_range(2 * step + 4)) - longint'(step) - 2;
            tgt    = fit_angle(longint'(cur) + offset + turns * FULL_TURN);
         end
         5, 6: begin
            offset = longint'($urandom_range(4)) - 2;
            if ($urandom_range(1) == 1) begin
               offset = -offset;
            end
            tgt = fit_angle(longint'(cur) + HALF_TURN + offset + turns * FULL_TURN);
         end
         7: begin
            offset = longint'($urandom_range(4)) - 2;
            tgt    = fit_angle(longint'(cur) - (FULL_TURN - longint'(step)) + offset);
         end
         8: begin
            cur = fit_angle(turns * FULL_TURN + longint'($urandom_range(6)) - 3);
            tgt = fit_angle(longint'($urandom_range(6)) - 3
                            + (longint'($urandom_range(6)) - 3) * FULL_TURN);
            step = STEP_W'($urandom_range(8));
         end
         9: begin
            step = STEP_W'($urandom_range(524287));
         end
         default: begin
         end
      endcase
   endtask

   // call right after a rising edge; returns at the edge that takes the request
   task automatic drive_request(input logic signed [IN_W-1:0] cur,
                                input logic signed [IN_W-1:0] tgt,
                                input logic [STEP_W-1:0] step,
                                input logic [ANG_W-1:0] angle);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_current_angle <= cur;
      req_target_angle  <= tgt;
      req_step_size     <= step;
      do @(posedge clock); while (busy);
      next_angle_q.push_back(angle);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (next_angle_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual next_angle %0d",
                     $time, rsp_next_angle);
            mismatch_count++;
         end else begin
            if (rsp_next_angle !== next_angle_q[0]) begin
               $display("%0t: next_angle mismatch, expected %0d, actual %0d",
                        $time, next_angle_q[0], rsp_next_angle);
               mismatch_count++;
            end
            void'(next_angle_q.pop_front());
         end
      end
   end

   initial begin
      logic signed [IN_W-1:0] cur;
      logic signed [IN_W-1:0] tgt;
      logic [STEP_W-1:0]      step;
      int                     wait_cycles;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (plan[i]) begin
         drive_request(plan[i].cur, plan[i].tgt, plan[i].step,
                       plan[i].known ? plan[i].angle
                                     : slew_toward(plan[i].cur, plan[i].tgt, plan[i].step));
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_LEN == 0) begin
            case ((n / PHASE_LEN) % 3)
               0: idle_pct = 0;
               1: idle_pct = 82;
               default: idle_pct = 11;
            endcase
         end
         make_request(cur, tgt, step);
         drive_request(cur, tgt, step, slew_toward(cur, tgt, step));
      end
      start <= 1'b0;
      wait_cycles = 0;
      while (next_angle_q.size() != 0 && wait_cycles < 200) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (6) @(posedge clock);
      if (next_angle_q.size() != 0) begin
         $display("%0t: %0d expected results never arrived, expected next_angle %0d",
                  $time, next_angle_q.size(), next_angle_q[0]);
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

[circular_angle_slew_limiter_unit.f]
rtl/casl_pkg.sv
rtl/circular_angle_slew_limiter_unit.sv
rtl/casl_checker.sv
dv/circular_angle_slew_limiter_unit_tb.sv
